// ===== rtl/core/dlr_pkg.sv =====
package dlr_pkg;

    localparam int COORD_BITS  = 8;
    localparam int ERR_BITS    = COORD_BITS + 1;
    localparam int COLOUR_BITS = 16;
    localparam int PAT_BITS    = 8;
    localparam int PPOS_BITS   = 3;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOUR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [PAT_BITS-1:0] PATTERN_TOP = 8'h80;

    localparam logic [PAT_BITS-1:0]    DASH_RESET  = 8'hFF;
    localparam logic [COLOUR_BITS-1:0] POINT_RESET = 16'hFFFF;
    localparam logic [COLOUR_BITS-1:0] BG_RESET    = 16'h0000;

    typedef logic [COORD_BITS-1:0]  t_coord;
    typedef logic [ERR_BITS-1:0]    t_err;
    typedef logic [COLOUR_BITS-1:0] t_colour;

    typedef enum logic [1:0] {
        REG_DASH  = 2'd0,
        REG_POINT = 2'd1,
        REG_BG    = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        t_op    op;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_cmd;

    typedef struct packed {
        logic [PAT_BITS-1:0] dash_pattern;
        t_colour             point_colour;
        t_colour             background_colour;
    } t_cfg;

endpackage

// ===== rtl/core/dlr_cfg.sv =====
module dlr_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dlr_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dlr_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [dlr_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output dlr_pkg::t_cfg                      o_cfg
);
    import dlr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dash_pattern      <= DASH_RESET;
            r_cfg.point_colour      <= POINT_RESET;
            r_cfg.background_colour <= BG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DASH:  r_cfg.dash_pattern      <= pwdata[PAT_BITS-1:0];
                REG_POINT: r_cfg.point_colour      <= pwdata[COLOUR_BITS-1:0];
                REG_BG:    r_cfg.background_colour <= pwdata[COLOUR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DASH:  prdata = APB_DATA_BITS'(r_cfg.dash_pattern);
            REG_POINT: prdata = APB_DATA_BITS'(r_cfg.point_colour);
            REG_BG:    prdata = APB_DATA_BITS'(r_cfg.background_colour);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/dlr_in_stage.sv =====
module dlr_in_stage (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y from the lowest bit up.
    input  logic [dlr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // tuser: operation.
    input  logic                              s_axis_tuser,
    output logic                              o_cmd_valid,
    output dlr_pkg::t_cmd                     o_cmd,
    input  logic                              i_cmd_ready
);
    import dlr_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;

    assign s_axis_tready = !r_valid || i_cmd_ready;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_cmd.op      = t_op'(s_axis_tuser);
        n_cmd.start_x = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
        n_cmd.start_y = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
        n_cmd.end_x   = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        n_cmd.end_y   = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== rtl/core/dlr_walk.sv =====
module dlr_walk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dlr_pkg::t_cfg                      i_cfg,
    input  logic                               i_cmd_valid,
    input  dlr_pkg::t_cmd                      i_cmd,
    output logic                               o_cmd_ready,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_colour from the lowest bit up.
    output logic [dlr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // tlast: last_pixel.
    output logic                               m_axis_tlast
);
    import dlr_pkg::*;

    // Walk state.
    t_coord                r_cur_x, r_cur_y;
    t_err                  r_err_x, r_err_y;
    t_coord                r_adx, r_ady, r_span;
    t_dir                  r_dir_x, r_dir_y;
    t_err                  r_step_idx;
    logic [PPOS_BITS-1:0]  r_ppos;
    logic                  r_active;

    t_coord                n_cur_x, n_cur_y;
    t_err                  n_err_x, n_err_y;
    t_coord                n_adx, n_ady, n_span;
    t_dir                  n_dir_x, n_dir_y;
    t_err                  n_step_idx;
    logic [PPOS_BITS-1:0]  n_ppos;
    logic                  n_active;

    // Result register.
    logic                  r_out_valid;
    t_coord                r_px, r_py;
    t_colour               r_pcol;
    logic                  r_plast;

    logic    w_emit, w_out_free, w_fire, w_last, w_bit;
    t_err    w_sum_x, w_sum_y, w_span_ext;
    t_colour w_colour;

    function automatic t_coord axis_move(input t_coord pos, input t_dir dir);
        t_coord res;
        unique case (dir)
            DIR_UP:   res = pos + 1'b1;
            DIR_DOWN: res = pos - 1'b1;
            default:  res = pos;
        endcase
        return res;
    endfunction

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_emit      = i_cmd_valid && (i_cmd.op == OP_STEP) && r_active;
    // Loads and steps on an idle walker never wait for the output side.
    assign o_cmd_ready = !w_emit || w_out_free;
    assign w_fire      = i_cmd_valid && o_cmd_ready;

    assign w_span_ext = ERR_BITS'(r_span);
    assign w_last     = (r_step_idx == w_span_ext + 1'b1);
    assign w_bit      = |(i_cfg.dash_pattern & (PATTERN_TOP >> r_ppos));
    assign w_colour   = w_bit ? i_cfg.point_colour : i_cfg.background_colour;
    assign w_sum_x    = r_err_x + ERR_BITS'(r_adx);
    assign w_sum_y    = r_err_y + ERR_BITS'(r_ady);

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_err_x    = r_err_x;
        n_err_y    = r_err_y;
        n_adx      = r_adx;
        n_ady      = r_ady;
        n_span     = r_span;
        n_dir_x    = r_dir_x;
        n_dir_y    = r_dir_y;
        n_step_idx = r_step_idx;
        n_ppos     = r_ppos;
        n_active   = r_active;
        if (w_fire && (i_cmd.op == OP_LOAD)) begin
            priority if (i_cmd.end_x > i_cmd.start_x) begin
                n_adx   = i_cmd.end_x - i_cmd.start_x;
                n_dir_x = DIR_UP;
            end else if (i_cmd.end_x < i_cmd.start_x) begin
                n_adx   = i_cmd.start_x - i_cmd.end_x;
                n_dir_x = DIR_DOWN;
            end else begin
                n_adx   = '0;
                n_dir_x = DIR_NONE;
            end
            priority if (i_cmd.end_y > i_cmd.start_y) begin
                n_ady   = i_cmd.end_y - i_cmd.start_y;
                n_dir_y = DIR_UP;
            end else if (i_cmd.end_y < i_cmd.start_y) begin
                n_ady   = i_cmd.start_y - i_cmd.end_y;
                n_dir_y = DIR_DOWN;
            end else begin
                n_ady   = '0;
                n_dir_y = DIR_NONE;
            end
            n_span     = (n_adx > n_ady) ? n_adx : n_ady;
            n_cur_x    = i_cmd.start_x;
            n_cur_y    = i_cmd.start_y;
            n_err_x    = '0;
            n_err_y    = '0;
            n_step_idx = '0;
            n_ppos     = '0;
            n_active   = 1'b1;
        end else if (w_fire && w_emit) begin
            n_ppos  = r_ppos + 1'b1;
            n_err_x = w_sum_x;
            n_err_y = w_sum_y;
            // An axis steps only when its error strictly exceeds the span.
            if (w_sum_x > w_span_ext) begin
                n_err_x = w_sum_x - w_span_ext;
                n_cur_x = axis_move(r_cur_x, r_dir_x);
            end
            if (w_sum_y > w_span_ext) begin
                n_err_y = w_sum_y - w_span_ext;
                n_cur_y = axis_move(r_cur_y, r_dir_y);
            end
            n_step_idx = r_step_idx + 1'b1;
            if (w_last) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_err_x    <= '0;
            r_err_y    <= '0;
            r_adx      <= '0;
            r_ady      <= '0;
            r_span     <= '0;
            r_dir_x    <= DIR_NONE;
            r_dir_y    <= DIR_NONE;
            r_step_idx <= '0;
            r_ppos     <= '0;
            r_active   <= 1'b0;
        end else begin
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_err_x    <= n_err_x;
            r_err_y    <= n_err_y;
            r_adx      <= n_adx;
            r_ady      <= n_ady;
            r_span     <= n_span;
            r_dir_x    <= n_dir_x;
            r_dir_y    <= n_dir_y;
            r_step_idx <= n_step_idx;
            r_ppos     <= n_ppos;
            r_active   <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_px    <= r_cur_x;
            r_py    <= r_cur_y;
            r_pcol  <= w_colour;
            r_plast <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_plast;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_pcol, r_py, r_px});

endmodule

// ===== rtl/core/dashed_line_rasterizer.sv =====
// Dashed line rasterizer.
// Input stream: tuser carries the operation, tdata the two endpoints. A load
// item latches the endpoints and restarts the walk without producing output;
// each step item produces one pixel while a line is active and nothing when
// no line is active. A line of longer span S gives S+2 pixels, the first
// point twice; the final one is marked with tlast on the output stream.
// Output stream: tdata carries x, y and the RGB565 colour picked by the dash
// pattern bit (top bit first, wrapping every eight pixels).
// A step item accepted at the input handshake is registered in the input stage
// and its pixel is then loaded into the output register, which holds it until
// the receiver takes it. Throughput is one item per clock while the receiver
// does not stall; the walker's error-term add and compare is the single loop
// that sets it.
// When the receiver stalls, the pixel holds in the output register and the
// input stage keeps accepting until a step item needs that register; loads
// pass through regardless. Reset clears both stages, makes the walker idle
// and sets the pattern to all ones, point colour to white, background to black.
// The APB registers (dash pattern, point colour, background colour at 0, 4, 8)
// are for the user to write only while the stream is idle; the block does not enforce it.
module dashed_line_rasterizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y from the lowest bit up.
    input  logic [dlr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // tuser: operation.
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_colour from the lowest bit up.
    output logic [dlr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // tlast: last_pixel.
    output logic                               m_axis_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dlr_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dlr_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [dlr_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import dlr_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    dlr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dlr_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_ready   (w_cmd_ready)
    );

    dlr_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_ready   (w_cmd_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/dlr_checker.sv =====
module dlr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [dlr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input logic                               m_axis_tlast
);
    import dlr_pkg::*;

    // A stalled pixel keeps its value and its last flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output item changed while stalled");

    // The input side only backs up when a pixel is waiting on the output side.
    a_back_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("pipeline not empty after reset");

    // An input item offered while the output register is empty is always taken.
    a_take_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && !m_axis_tvalid) |-> s_axis_tready)
        else $error("input item refused with an empty output register");

endmodule

bind dashed_line_rasterizer dlr_checker u_dlr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/dashed_line_rasterizer_checker.sv =====
module dashed_line_rasterizer_checker
    import dlr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  logic                      i_cmd_ready,
    // Command payload: start_x, start_y, end_x, end_y from the lowest bit up.
    input  logic [IN_DATA_BITS-1:0]   i_cmd_data,
    // Command kind: operation.
    input  logic                      i_cmd_op,
    input  logic                      i_pix_valid,
    input  logic                      i_pix_ready,
    // Pixel payload: pixel_x, pixel_y, pixel_colour from the lowest bit up.
    input  logic [OUT_DATA_BITS-1:0]  i_pix_data,
    input  logic                      i_pix_last,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [APB_ADDR_BITS-1:0]  i_paddr,
    input  logic [APB_DATA_BITS-1:0]  i_pwdata,
    input  logic                      i_pready,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_pixels
);

    typedef struct packed {
        logic    is_last;
        t_colour colour;
        t_coord  y;
        t_coord  x;
    } t_pixel;

    t_pixel pixels_due[$];
    int     mismatches = 0;
    int     pixels_seen = 0;

    logic [PAT_BITS-1:0] dash_reg;
    t_colour             point_reg;
    t_colour             bg_reg;

    t_coord              cur_x, cur_y;
    t_err                err_x, err_y;
    t_coord              mag_x, mag_y, span;
    t_dir                dir_x, dir_y;
    t_err                pixels_done;
    logic [PPOS_BITS-1:0] pat_pos;
    bit                  walking;

    function automatic void setup_axis(input t_coord src, input t_coord dst,
                                       output t_coord mag, output t_dir dir);
        if (dst > src) begin
            mag = dst - src;
            dir = DIR_UP;
        end else if (dst < src) begin
            mag = src - dst;
            dir = DIR_DOWN;
        end else begin
            mag = '0;
            dir = DIR_NONE;
        end
    endfunction

    function automatic t_coord move_axis(input t_coord pos, input t_dir dir);
        case (dir)
            DIR_UP:   return pos + 1'b1;
            DIR_DOWN: return pos - 1'b1;
            default:  return pos;
        endcase
    endfunction

    function void note_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    task clear_walker();
        cur_x = '0;
        cur_y = '0;
        err_x = '0;
        err_y = '0;
        mag_x = '0;
        mag_y = '0;
        span = '0;
        dir_x = DIR_NONE;
        dir_y = DIR_NONE;
        pixels_done = '0;
        pat_pos = '0;
        walking = 1'b0;
    endtask

    task start_line(input logic [IN_DATA_BITS-1:0] ends);
        t_coord sx, sy, ex, ey;
        sx = ends[COORD_BITS-1:0];
        sy = ends[2*COORD_BITS-1:COORD_BITS];
        ex = ends[3*COORD_BITS-1:2*COORD_BITS];
        ey = ends[4*COORD_BITS-1:3*COORD_BITS];
        setup_axis(sx, ex, mag_x, dir_x);
        setup_axis(sy, ey, mag_y, dir_y);
        span = (mag_x > mag_y) ? mag_x : mag_y;
        cur_x = sx;
        cur_y = sy;
        err_x = '0;
        err_y = '0;
        pixels_done = '0;
        pat_pos = '0;
        walking = 1'b1;
    endtask

    // One step of the walk: emit the pixel at the cursor, then advance the
    // error terms and move on any axis whose term passes the span.
    task advance_walk();
        t_pixel px;
        if (!walking)
            return;
        px.x = cur_x;
        px.y = cur_y;
        px.colour = ((dash_reg & (PATTERN_TOP >> pat_pos)) != '0) ? point_reg : bg_reg;
        px.is_last = (pixels_done == t_err'(span) + 1'b1);
        pixels_due.push_back(px);
        pat_pos = pat_pos + 1'b1;
        err_x = err_x + t_err'(mag_x);
        err_y = err_y + t_err'(mag_y);
        if (err_x > t_err'(span)) begin
            err_x = err_x - t_err'(span);
            cur_x = move_axis(cur_x, dir_x);
        end
        if (err_y > t_err'(span)) begin
            err_y = err_y - t_err'(span);
            cur_y = move_axis(cur_y, dir_y);
        end
        pixels_done = pixels_done + 1'b1;
        if (px.is_last)
            walking = 1'b0;
    endtask

    task compare_pixel();
        t_pixel want;
        t_pixel got;
        got.x = i_pix_data[COORD_BITS-1:0];
        got.y = i_pix_data[2*COORD_BITS-1:COORD_BITS];
        got.colour = i_pix_data[2*COORD_BITS+COLOUR_BITS-1:2*COORD_BITS];
        got.is_last = i_pix_last;
        pixels_seen++;
        if (pixels_due.size() == 0) begin
            note_mismatch("unexpected pixel, x", 0, got.x);
            return;
        end
        want = pixels_due.pop_front();
        if (got.x !== want.x)
            note_mismatch("pixel_x", want.x, got.x);
        if (got.y !== want.y)
            note_mismatch("pixel_y", want.y, got.y);
        if (got.colour !== want.colour)
            note_mismatch("pixel_colour", want.colour, got.colour);
        if (got.is_last !== want.is_last)
            note_mismatch("last_pixel", want.is_last, got.is_last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dash_reg = DASH_RESET;
            point_reg = POINT_RESET;
            bg_reg = BG_RESET;
            clear_walker();
            pixels_due.delete();
        end else begin
            if (i_pix_valid && i_pix_ready)
                compare_pixel();
            if (i_cmd_valid && i_cmd_ready) begin
                if (t_op'(i_cmd_op) == OP_STEP)
                    advance_walk();
                else
                    start_line(i_cmd_data);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_DASH:  dash_reg = i_pwdata[PAT_BITS-1:0];
                    REG_POINT: point_reg = i_pwdata[COLOUR_BITS-1:0];
                    REG_BG:    bg_reg = i_pwdata[COLOUR_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= pixels_due.size();
        o_errors <= mismatches;
        o_pixels <= pixels_seen;
    end

endmodule

// ===== tb/dashed_line_rasterizer_tb.sv =====
module dashed_line_rasterizer_tb;
    import dlr_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 240;
    localparam int LIMIT_CYCLES  = 600000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    int errors;
    int pending;
    int pixels;

    bit quiet = 1'b0;
    bit long_hold_due = 1'b0;
    int send_gap_pct = 0;
    int stall_pct = 0;
    int loads_sent = 0;
    int steps_sent = 0;
    int phase_items = 0;
    int settings_used = 0;

    always #CLK_HALF i_clk = ~i_clk;

    dashed_line_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dashed_line_rasterizer_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd_ready (s_axis_tready),
        .i_cmd_data  (s_axis_tdata),
        .i_cmd_op    (s_axis_tuser),
        .i_pix_valid (m_axis_tvalid),
        .i_pix_ready (m_axis_tready),
        .i_pix_data  (m_axis_tdata),
        .i_pix_last  (m_axis_tlast),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_pixels    (pixels)
    );

    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("timeout with %0d pixels still expected", pending);
        $display("simulation failed");
        $finish;
    end

    // Pixel receiver: random stall bursts, plus one long hold-off on request
    // so that the block backs up into its input.
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task send_item(input t_op op, input logic [IN_DATA_BITS-1:0] data);
        if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (op == OP_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    task send_load(input t_coord sx, input t_coord sy, input t_coord ex, input t_coord ey);
        send_item(OP_LOAD, {ey, ex, sy, sx});
    endtask

    // Step items carry random payload, which the block must ignore.
    task send_steps(input int count);
        repeat (count) send_item(OP_STEP, $urandom());
    endtask

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_coord near(input t_coord c, input int reach);
        int off;
        off = $urandom_range(0, 2 * reach);
        return t_coord'(int'(c) + off - reach);
    endfunction

    function automatic int line_span(input t_coord sx, input t_coord sy,
                                     input t_coord ex, input t_coord ey);
        int ax, ay;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        return (ax > ay) ? ax : ay;
    endfunction

    // A load followed by its full run of steps, now and then cut short by
    // the next load or followed by steps that find no active line.
    task random_line();
        t_coord sx, sy, ex, ey;
        int reach, full, steps;
        reach = ($urandom_range(0, 29) == 0) ? 255 : (($urandom_range(0, 3) == 0) ? 40 : 8);
        sx = pick_coord();
        sy = pick_coord();
        if (reach == 255) begin
            ex = pick_coord();
            ey = pick_coord();
        end else begin
            ex = near(sx, reach);
            ey = near(sy, reach);
        end
        case ($urandom_range(0, 15))
            0:       begin ex = sx; ey = sy; end
            1:       ex = sx;
            2:       ey = sy;
            default: ;
        endcase
        full = line_span(sx, sy, ex, ey) + 2;
        steps = full;
        case ($urandom_range(0, 9))
            0:       steps = $urandom_range(0, full - 1);
            1:       steps = full + $urandom_range(1, 2);
            default: ;
        endcase
        send_load(sx, sy, ex, ey);
        send_steps(steps);
        phase_items += 1 + ((steps < full) ? steps : full);
    endtask

    task run_phase(input int target);
        int pick;
        phase_items = 0;
        while (phase_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                random_line();
            end else if (pick < 90) begin
                send_steps(1);
            end else begin
                send_load(pick_coord(), pick_coord(), pick_coord(), pick_coord());
                phase_items++;
            end
        end
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task apb_write(input t_reg_idx idx, input logic [APB_DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper write-data bits are random; the block must drop them.
    task configure(input logic [PAT_BITS-1:0] dash, input t_colour point, input t_colour bg);
        drain();
        apb_write(REG_DASH, {24'($urandom()), dash});
        apb_write(REG_POINT, {16'($urandom()), point});
        apb_write(REG_BG, {16'($urandom()), bg});
        send_gap_pct = $urandom_range(0, 25);
        stall_pct = $urandom_range(0, 25);
        settings_used++;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser <= OP_LOAD;
        s_axis_tdata <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: step with no line, equal endpoints at the
        // top corner, a line abandoned by a new load, then short walks.
        send_steps(1);
        send_load('1, '1, '1, '1);
        send_steps(3);
        send_load('0, '1, 8'd3, 8'd252);
        send_steps(2);
        send_load('1, '0, 8'd250, 8'd2);
        send_steps(7);
        send_load('0, '0, 8'd4, 8'd2);
        send_steps(6);

        configure(8'h00, 16'h0000, 16'hFFFF);
        run_phase(PHASE_ITEMS);
        configure(8'hFF, 16'hFFFF, 16'h0000);
        long_hold_due = 1'b1;
        run_phase(PHASE_ITEMS);
        configure(8'hAA, 16'hF800, 16'h07E0);
        run_phase(PHASE_ITEMS);
        configure(8'h80, 16'h001F, 16'hFFFF);
        run_phase(PHASE_ITEMS);
        configure(8'h01, t_colour'($urandom()), t_colour'($urandom()));
        run_phase(PHASE_ITEMS);
        configure(8'($urandom()), t_colour'($urandom()), t_colour'($urandom()));
        run_phase(PHASE_ITEMS);
        configure(8'($urandom()), t_colour'($urandom()), t_colour'($urandom()));
        run_phase(PHASE_ITEMS);
        configure(8'($urandom()), t_colour'($urandom()), t_colour'($urandom()));
        quiet = 1'b1;
        run_phase(150);
        drain();

        $display("Sent %0d loads and %0d steps under %0d register settings plus reset values,",
                 loads_sent, steps_sent, settings_used);
        $display("with one long output hold-off; %0d pixels compared.", pixels);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dlr_pkg.sv
rtl/core/dlr_cfg.sv
rtl/core/dlr_in_stage.sv
rtl/core/dlr_walk.sv
rtl/core/dashed_line_rasterizer.sv
rtl/core/dlr_checker.sv
tb/dashed_line_rasterizer_checker.sv
tb/dashed_line_rasterizer_tb.sv
